@@ src/mfx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfx_pkg
// shared types and constants of the midi effect unit
// ----------------------------------------------------------------------------
package mfx_pkg;
    localparam int HeldDepth = 16;
    localparam int MaxBurst  = 16;
    localparam int HIW       = $clog2(HeldDepth);
    localparam int HCW       = $clog2(HeldDepth + 1);
    localparam logic [6:0] PitchMax = 7'd127;

    localparam logic [2:0] MODE_PASS  = 3'd0;
    localparam logic [2:0] MODE_CHORD = 3'd1;
    localparam logic [2:0] MODE_TRANS = 3'd2;
    localparam logic [2:0] MODE_VEL   = 3'd3;
    localparam logic [2:0] MODE_ARP   = 3'd4;

    localparam logic [1:0] PAT_DOWN   = 2'd1;
    localparam logic [1:0] PAT_UPDOWN = 2'd2;

    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_OFF1  = 3'd1;
    localparam logic [2:0] REG_OFF2  = 3'd2;
    localparam logic [2:0] REG_OFF3  = 3'd3;
    localparam logic [2:0] REG_PAT   = 3'd4;
    localparam logic [2:0] REG_GAIN  = 3'd5;
    localparam logic [2:0] REG_LIMIT = 3'd6;

    typedef struct packed {
        logic [2:0]        fx_mode;
        logic signed [7:0] first_offset;
        logic signed [7:0] second_offset;
        logic signed [7:0] third_offset;
        logic [1:0]        arp_pattern;
        logic [7:0]        velocity_gain;
        logic [4:0]        output_limit;
    } t_cfg;

    typedef struct packed {
        logic        req_type;
        logic [6:0]  note_pitch;
        logic [6:0]  note_velocity;
        logic        note_on;
        logic [31:0] timestamp;
        logic [4:0]  tick_count;
    } t_in;

    typedef struct packed {
        logic [6:0]  out_pitch;
        logic [6:0]  out_velocity;
        logic        out_note_on;
        logic [31:0] out_timestamp;
        logic        last_of_run;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_SCAN, S_CHORD, S_EMIT, S_SEARCH, S_SHIFT,
        S_TICK, S_MOD, S_TICK_EMIT, S_ADVANCE
    } t_state;
endpackage
`default_nettype wire

@@ src/mfx_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfx_in_if / mfx_out_if / mfx_cfg_if
// valid-ready channels of the effect unit
// ----------------------------------------------------------------------------
interface mfx_in_if import mfx_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mfx_out_if import mfx_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mfx_cfg_if ();
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

@@ src/mfx_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfx_regs
// configuration register file
// ----------------------------------------------------------------------------
module mfx_regs import mfx_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    mfx_cfg_if.sink cfg,
    output t_cfg o_cfg
);
    t_cfg r_cfg;
    assign cfg.ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
            r_cfg.output_limit <= 5'd16;
        end else if (cfg.valid) begin
            case (cfg.index)
                REG_MODE:  r_cfg.fx_mode <= cfg.wdata[2:0];
                REG_OFF1:  r_cfg.first_offset <= cfg.wdata;
                REG_OFF2:  r_cfg.second_offset <= cfg.wdata;
                REG_OFF3:  r_cfg.third_offset <= cfg.wdata;
                REG_PAT:   r_cfg.arp_pattern <= cfg.wdata[1:0];
                REG_GAIN:  r_cfg.velocity_gain <= cfg.wdata;
                REG_LIMIT: r_cfg.output_limit <= cfg.wdata[4:0];
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ src/mfx_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfx_core
// sequencer with one shared adder/compare unit and the held-note store
// ----------------------------------------------------------------------------
module mfx_core import mfx_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_cfg i_cfg,
    mfx_in_if.sink  in_ch,
    mfx_out_if.source out_ch
);
    localparam int LimW = $clog2(MaxBurst + 1) > 5 ? $clog2(MaxBurst + 1) : 5;

    t_state r_state, n_state;
    t_in    r_in;
    logic [6:0] r_held [HeldDepth];
    logic [HCW-1:0] r_count;
    logic [HCW-1:0] r_pos;
    logic r_dir;
    logic [6:0] r_lastvel;
    logic [HCW-1:0] r_idx;
    logic [1:0] r_voice;
    logic [3:0] r_vmask;
    logic [4:0] r_ticks;
    logic [LimW-1:0] r_limit;
    logic [LimW-1:0] r_nout;
    t_out r_out;
    logic r_ovalid;
    logic [14:0] r_prod;

    // shared unit: signed 10-bit add of pitch and selected offset
    logic signed [7:0] w_off;
    logic signed [9:0] w_sum;
    logic [LimW-1:0] w_lim_eff;
    logic [HIW-1:0] w_hidx;
    logic w_out_free;
    logic [6:0] w_hnote;
    logic [14:0] w_rvel;
    logic w_voice_ok;
    logic w_chord_send;
    logic w_later;
    logic w_emit;

    always_comb begin
        case (r_voice)
            2'd1:    w_off = i_cfg.second_offset;
            2'd2:    w_off = i_cfg.third_offset;
            default: w_off = i_cfg.first_offset;
        endcase
    end
    assign w_sum = $signed({3'b000, r_in.note_pitch}) + 10'(w_off);
    assign w_lim_eff = (LimW'(i_cfg.output_limit) > LimW'(MaxBurst)) ? LimW'(MaxBurst)
                     : LimW'(i_cfg.output_limit);
    assign w_hidx = r_idx[HIW-1:0];
    assign w_hnote = r_held[w_hidx];
    assign w_out_free = !r_ovalid || out_ch.ready;
    assign w_rvel = (r_prod + 15'd16) >> 5;

    assign w_voice_ok = (w_off != 0) && (w_sum >= 0) && (w_sum <= 10'sd127);
    assign w_chord_send = (r_voice != 2'd3) && (r_nout != r_limit) && r_vmask[r_voice];
    // any usable voice after the current one
    assign w_later = |(r_vmask >> ({1'b0, r_voice} + 3'd1));
    assign w_emit = w_out_free && ((r_state == S_EMIT) || (r_state == S_TICK_EMIT)
                                   || (r_state == S_CHORD && w_chord_send));

    assign in_ch.ready = (r_state == S_IDLE);
    assign out_ch.valid = r_ovalid;
    assign out_ch.data = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (in_ch.valid) n_state = S_DISPATCH;
            S_DISPATCH: begin
                if (r_in.req_type) begin
                    n_state = (i_cfg.fx_mode == MODE_ARP) ? S_TICK : S_IDLE;
                end else if (i_cfg.fx_mode == MODE_ARP) begin
                    n_state = S_SEARCH;
                end else if (r_limit == '0) begin
                    n_state = S_IDLE;
                end else if (i_cfg.fx_mode == MODE_CHORD) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SCAN:      if (r_voice == 2'd2) n_state = S_EMIT;
            S_EMIT:      if (w_out_free) n_state = (i_cfg.fx_mode == MODE_CHORD) ? S_CHORD
                                                 : S_IDLE;
            S_CHORD:     if (w_out_free) n_state = (r_voice == 2'd3 || r_nout == r_limit)
                                                 ? S_IDLE : S_CHORD;
            S_SEARCH: begin
                if (r_idx == r_count) n_state = S_IDLE;
                else if (w_hnote == r_in.note_pitch)
                    n_state = r_in.note_on ? S_IDLE : S_SHIFT;
            end
            S_SHIFT:     if (r_idx + 1'b1 >= r_count) n_state = S_IDLE;
            S_TICK:      n_state = (r_ticks == '0 || r_nout == r_limit || r_count == '0)
                                   ? S_IDLE : S_MOD;
            S_MOD:       if (r_idx < r_count) n_state = S_TICK_EMIT;
            S_TICK_EMIT: if (w_out_free) n_state = S_ADVANCE;
            S_ADVANCE:   n_state = S_TICK;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pos <= '0;
            r_dir <= 1'b1;
            r_lastvel <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= w_emit || (r_ovalid && !out_ch.ready);
            case (r_state)
                S_IDLE: if (in_ch.valid) begin
                    r_in <= in_ch.data;
                    r_voice <= 2'd0;
                    r_vmask <= '0;
                    r_nout <= '0;
                    r_idx <= '0;
                    r_ticks <= in_ch.data.tick_count;
                    r_limit <= w_lim_eff;
                end
                S_DISPATCH: begin
                    r_prod <= r_in.note_velocity * i_cfg.velocity_gain;
                    if (!r_in.req_type && i_cfg.fx_mode == MODE_ARP && r_in.note_on)
                        r_lastvel <= r_in.note_velocity;
                end
                // voices are checked one per cycle through the shared adder
                S_SCAN: begin
                    r_vmask[r_voice] <= w_voice_ok;
                    r_voice <= (r_voice == 2'd2) ? 2'd0 : r_voice + 1'b1;
                end
                S_EMIT: if (w_out_free) begin
                    r_nout <= r_nout + 1'b1;
                    r_out.out_pitch <= (i_cfg.fx_mode != MODE_TRANS) ? r_in.note_pitch
                        : (w_sum < 0) ? 7'd0
                        : (w_sum > 10'sd127) ? PitchMax : w_sum[6:0];
                    r_out.out_velocity <= (i_cfg.fx_mode != MODE_VEL) ? r_in.note_velocity
                        : (w_rvel > 15'd127) ? PitchMax : w_rvel[6:0];
                    r_out.out_note_on <= r_in.note_on;
                    r_out.out_timestamp <= r_in.timestamp;
                    r_out.last_of_run <= (i_cfg.fx_mode != MODE_CHORD)
                                         || (r_limit == LimW'(1)) || (r_vmask == '0);
                end
                S_CHORD: if (w_out_free) begin
                    r_voice <= r_voice + 1'b1;
                    if (w_chord_send) begin
                        r_nout <= r_nout + 1'b1;
                        r_out.out_pitch <= w_sum[6:0];
                        r_out.last_of_run <= !w_later || (r_nout + 1'b1 == r_limit);
                    end
                end
                S_SEARCH: begin
                    if (r_idx == r_count) begin
                        if (r_in.note_on && r_count < HCW'(HeldDepth)) begin
                            r_held[w_hidx] <= r_in.note_pitch;
                            r_count <= r_count + 1'b1;
                        end
                        if (!r_in.note_on && r_count == '0) r_pos <= '0;
                    end else if (w_hnote != r_in.note_pitch) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SHIFT: begin
                    if (r_idx + 1'b1 >= r_count) begin
                        r_count <= r_count - 1'b1;
                        if (r_count == HCW'(1)) r_pos <= '0;
                    end else begin
                        r_held[w_hidx] <= r_held[HIW'(r_idx + 1'b1)];
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_TICK: r_idx <= r_pos;
                // position modulo held count by repeated subtraction
                S_MOD: if (r_idx >= r_count) r_idx <= r_idx - r_count;
                S_TICK_EMIT: if (w_out_free) begin
                    r_nout <= r_nout + 1'b1;
                    r_ticks <= r_ticks - 1'b1;
                    r_out.out_pitch <= w_hnote;
                    r_out.out_velocity <= r_lastvel;
                    r_out.out_note_on <= 1'b1;
                    r_out.out_timestamp <= '0;
                    r_out.last_of_run <= (r_ticks == 5'd1) || (r_nout + 1'b1 == r_limit);
                end
                S_ADVANCE: begin
                    if (i_cfg.arp_pattern == PAT_DOWN) begin
                        r_pos <= (r_pos == '0) ? r_count - 1'b1 : r_pos - 1'b1;
                    end else if (i_cfg.arp_pattern == PAT_UPDOWN) begin
                        if (r_dir) begin
                            if (r_pos + 1'b1 >= r_count) begin
                                r_dir <= 1'b0;
                                r_pos <= (r_count < HCW'(2)) ? '0 : r_count - HCW'(2);
                            end else r_pos <= r_pos + 1'b1;
                        end else begin
                            if (r_pos == '0) begin
                                r_dir <= 1'b1;
                                r_pos <= (r_count > HCW'(1)) ? HCW'(1) : '0;
                            end else r_pos <= r_pos - 1'b1;
                        end
                    end else begin
                        // r_idx holds the position already reduced modulo the count
                        r_pos <= (r_idx + 1'b1 >= r_count) ? '0 : r_idx + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ src/midi_fx_arpeggiator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_fx_arpeggiator_unit
// midi effect unit: passthrough, chord, transpose, velocity scale, arpeggiator
//
//  channel  dir  payload
//  i_cfg    in   register index, 8-bit data
//  i_in     in   note event or tick batch
//  o_out    out  emitted notes, last_of_run on the final one
//
// a note item is dispatched and emitted; a chord adds three voice checks, then one
// voice per cycle while the output is not stalled; an arpeggiator note event
// searches then shifts; a tick batch passes tick, modulo, emit and advance per note,
// reducing the position modulo the count; not ready until an item is done
// synchronous active-low reset; output stalls hold the sequencer
// ----------------------------------------------------------------------------
module midi_fx_arpeggiator_unit import mfx_pkg::*; (
    input  wire i_clk,
    input  wire i_rst_n,
    mfx_cfg_if.sink i_cfg,
    mfx_in_if.sink  i_in,
    mfx_out_if.source o_out
);
    t_cfg w_cfg;
    mfx_regs u_regs (.i_clk, .i_rst_n, .cfg(i_cfg), .o_cfg(w_cfg));
    mfx_core u_core (.i_clk, .i_rst_n, .i_cfg(w_cfg), .in_ch(i_in), .out_ch(o_out));
endmodule
`default_nettype wire

@@ src/mfx_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfx_checker
// port-level checks of the effect unit
// ----------------------------------------------------------------------------
module mfx_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire in_valid,
    input wire in_ready,
    input wire out_valid,
    input wire out_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("out dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready after transfer");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind midi_fx_arpeggiator_unit mfx_checker u_chk (
    .i_clk, .i_rst_n, .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready));
`default_nettype wire

@@ dv/tb_midi_fx_arpeggiator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_fx_arpeggiator_unit
// drives note events and tick batches through every effect mode and setting,
// predicts the emitted notes and checks each output transfer in order
// ----------------------------------------------------------------------------

class mfx_note_board;
    mfx_pkg::t_cfg cfg;
    logic [6:0] held [16];
    int held_n;
    int pos;
    int dir;
    logic [6:0] last_vel;
    mfx_pkg::t_out pending [$];
    int errors;

    function new();
        cfg = '0;
        cfg.output_limit = 5'd16;
        held_n = 0;
        pos = 0;
        dir = 1;
        last_vel = '0;
        errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] d);
        case (idx)
            mfx_pkg::REG_MODE:  cfg.fx_mode = d[2:0];
            mfx_pkg::REG_OFF1:  cfg.first_offset = d;
            mfx_pkg::REG_OFF2:  cfg.second_offset = d;
            mfx_pkg::REG_OFF3:  cfg.third_offset = d;
            mfx_pkg::REG_PAT:   cfg.arp_pattern = d[1:0];
            mfx_pkg::REG_GAIN:  cfg.velocity_gain = d;
            mfx_pkg::REG_LIMIT: cfg.output_limit = d[4:0];
            default: ;
        endcase
    endfunction

    function void push(logic [6:0] p, logic [6:0] v, logic on, logic [31:0] ts);
        mfx_pkg::t_out r;
        r.out_pitch = p;
        r.out_velocity = v;
        r.out_note_on = on;
        r.out_timestamp = ts;
        r.last_of_run = 1'b0;
        pending.push_back(r);
    endfunction

    function void step_position();
        if (cfg.arp_pattern == mfx_pkg::PAT_DOWN) begin
            pos--;
            if (pos < 0) pos = held_n - 1;
        end else if (cfg.arp_pattern == mfx_pkg::PAT_UPDOWN) begin
            pos += dir;
            if (pos >= held_n) begin
                dir = -1;
                pos = (held_n - 2 < 0) ? 0 : held_n - 2;
            end else if (pos < 0) begin
                dir = 1;
                pos = (held_n > 1) ? 1 : 0;
            end
        end else begin
            pos = (pos + 1) % held_n;
        end
    endfunction

    function void note_input(mfx_pkg::t_in it);
        int lim;
        int n;
        int p;
        int found;
        logic signed [7:0] offs [3];
        lim = (cfg.output_limit > 16) ? 16 : cfg.output_limit;
        n = 0;
        if (it.req_type) begin
            if (cfg.fx_mode != mfx_pkg::MODE_ARP) return;
            for (int t = 0; t < it.tick_count && n < lim && held_n > 0; t++) begin
                push(held[pos % held_n], last_vel, 1'b1, 32'd0);
                n++;
                step_position();
            end
        end else if (cfg.fx_mode == mfx_pkg::MODE_ARP) begin
            if (it.note_on) begin
                last_vel = it.note_velocity;
                found = 0;
                for (int i = 0; i < held_n; i++)
                    if (held[i] == it.note_pitch) found = 1;
                if (!found && held_n < 16) begin
                    held[held_n] = it.note_pitch;
                    held_n++;
                end
            end else begin
                for (int i = 0; i < held_n; i++) begin
                    if (held[i] == it.note_pitch) begin
                        for (int j = i; j < held_n - 1; j++) held[j] = held[j + 1];
                        held_n--;
                        i--;
                    end
                end
                if (held_n == 0) pos = 0;
            end
            return;
        end else if (lim >= 1) begin
            if (cfg.fx_mode == mfx_pkg::MODE_CHORD) begin
                offs[0] = cfg.first_offset;
                offs[1] = cfg.second_offset;
                offs[2] = cfg.third_offset;
                push(it.note_pitch, it.note_velocity, it.note_on, it.timestamp);
                n++;
                for (int i = 0; i < 3 && n < lim; i++) begin
                    p = int'(it.note_pitch) + int'(offs[i]);
                    if (offs[i] != 0 && p >= 0 && p <= 127) begin
                        push(p[6:0], it.note_velocity, it.note_on, it.timestamp);
                        n++;
                    end
                end
            end else if (cfg.fx_mode == mfx_pkg::MODE_TRANS) begin
                p = int'(it.note_pitch) + int'(cfg.first_offset);
                if (p < 0) p = 0;
                else if (p > 127) p = 127;
                push(p[6:0], it.note_velocity, it.note_on, it.timestamp);
                n++;
            end else if (cfg.fx_mode == mfx_pkg::MODE_VEL) begin
                p = (int'(it.note_velocity) * int'(cfg.velocity_gain) + 16) >> 5;
                if (p > 127) p = 127;
                push(it.note_pitch, p[6:0], it.note_on, it.timestamp);
                n++;
            end else begin
                push(it.note_pitch, it.note_velocity, it.note_on, it.timestamp);
                n++;
            end
        end
        if (n > 0) pending[$].last_of_run = 1'b1;
    endfunction

    task report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    task check_note(mfx_pkg::t_out got);
        mfx_pkg::t_out w;
        if (pending.size() == 0) begin
            report($sformatf("unexpected note %p", got));
            return;
        end
        w = pending.pop_front();
        if (got.out_pitch !== w.out_pitch)
            report($sformatf("pitch %0d want %0d", got.out_pitch, w.out_pitch));
        if (got.out_velocity !== w.out_velocity)
            report($sformatf("velocity %0d want %0d", got.out_velocity, w.out_velocity));
        if (got.out_note_on !== w.out_note_on)
            report($sformatf("note_on %0b want %0b", got.out_note_on, w.out_note_on));
        if (got.out_timestamp !== w.out_timestamp)
            report($sformatf("timestamp %0h want %0h", got.out_timestamp, w.out_timestamp));
        if (got.last_of_run !== w.last_of_run)
            report($sformatf("last_of_run %0b want %0b", got.last_of_run, w.last_of_run));
    endtask
endclass

module tb_midi_fx_arpeggiator_unit;
    import mfx_pkg::*;

    localparam int CycleLimit = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    longint cycles = 0;

    mfx_cfg_if cfg_ch ();
    mfx_in_if in_ch ();
    mfx_out_if out_ch ();

    mfx_note_board board;

    midi_fx_arpeggiator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // receiver: random stalls, checks every output transfer
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) board.check_note(out_ch.data);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one edge first so valid is never deasserted and reasserted in one step
    task automatic write_reg(logic [2:0] idx, logic [7:0] d);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.write_reg(idx, d);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_item(t_in it);
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_input(it);
        in_ch.valid <= 1'b0;
    endtask

    // idle before a register write; covers a long note-off search still running
    task automatic drain();
        int guard;
        guard = 0;
        while (board.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_in note_item(int p, int v, bit on);
        t_in it;
        it.req_type = 1'b0;
        it.note_pitch = p[6:0];
        it.note_velocity = v[6:0];
        it.note_on = on;
        it.timestamp = $urandom();
        it.tick_count = 5'($urandom_range(31));
        return it;
    endfunction

    function automatic t_in tick_item(int n);
        t_in it;
        it = note_item($urandom_range(127), $urandom_range(127), $urandom_range(1));
        it.req_type = 1'b1;
        it.tick_count = n[4:0];
        return it;
    endfunction

    task automatic random_setup();
        write_reg(REG_MODE, 8'($urandom_range(7)));
        write_reg(REG_OFF1, $urandom_range(3) == 0 ? 8'd0 : 8'($urandom_range(255)));
        write_reg(REG_OFF2, $urandom_range(3) == 0 ? 8'd0 : 8'($urandom_range(24) - 12));
        write_reg(REG_OFF3, $urandom_range(3) == 0 ? 8'd0 : 8'($urandom_range(255)));
        write_reg(REG_PAT, 8'($urandom_range(3)));
        write_reg(REG_GAIN, 8'($urandom_range(255)));
        write_reg(REG_LIMIT, $urandom_range(4) == 0 ? 8'($urandom_range(31))
                                                    : 8'($urandom_range(1, 16)));
    endtask

    task automatic random_item(logic [2:0] mode);
        int r;
        r = $urandom_range(99);
        if (mode == MODE_ARP) begin
            // mostly note-ons and ticks, some note-offs of held pitches and a few of random ones
            if (r < 40)
                send_item(note_item($urandom_range(127), $urandom_range(127), 1'b1));
            else if (r < 60 && board.held_n > 0)
                send_item(note_item(board.held[$urandom_range(board.held_n - 1)],
                                    $urandom_range(127), 1'b0));
            else if (r < 65)
                send_item(note_item($urandom_range(127), $urandom_range(127), 1'b0));
            else
                send_item(tick_item($urandom_range(r < 95 ? 16 : 31)));
        end else begin
            if (r < 8) send_item(tick_item($urandom_range(31)));
            else send_item(note_item($urandom_range(127), $urandom_range(127),
                                     $urandom_range(1)));
        end
    endtask

    initial begin
        int pct_s [3] = '{21, 70, 0};
        int pct_r [3] = '{70, 21, 0};
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each mode with extremes
        send_item(note_item(0, 0, 1'b0));
        send_item(note_item(127, 127, 1'b1));
        send_item(tick_item(16));
        drain();
        write_reg(REG_MODE, 8'(MODE_CHORD));
        write_reg(REG_OFF1, 8'd127);
        write_reg(REG_OFF2, 8'h81);
        write_reg(REG_OFF3, 8'd7);
        send_item(note_item(0, 100, 1'b1));
        send_item(note_item(127, 1, 1'b0));
        send_item(note_item(60, 64, 1'b1));
        drain();
        write_reg(REG_LIMIT, 8'd2);
        send_item(note_item(60, 64, 1'b1));
        drain();
        write_reg(REG_LIMIT, 8'd0);
        send_item(note_item(60, 64, 1'b1));
        drain();
        write_reg(REG_LIMIT, 8'd31);
        write_reg(REG_MODE, 8'(MODE_TRANS));
        send_item(note_item(127, 5, 1'b1));
        drain();
        write_reg(REG_OFF1, 8'h81);
        send_item(note_item(3, 5, 1'b1));
        drain();
        write_reg(REG_MODE, 8'(MODE_VEL));
        write_reg(REG_GAIN, 8'd255);
        send_item(note_item(10, 127, 1'b1));
        drain();
        write_reg(REG_GAIN, 8'd16);
        send_item(note_item(10, 1, 1'b1));
        send_item(note_item(10, 3, 1'b0));
        drain();
        write_reg(REG_MODE, 8'd7);
        send_item(note_item(55, 55, 1'b1));
        drain();
        write_reg(REG_MODE, 8'(MODE_ARP));
        write_reg(REG_PAT, 8'(PAT_UPDOWN));
        send_item(tick_item(4));
        for (int i = 0; i < 3; i++) send_item(note_item(40 + 3 * i, 90, 1'b1));
        send_item(note_item(43, 90, 1'b1));
        send_item(tick_item(16));
        send_item(note_item(43, 0, 1'b0));
        send_item(tick_item(5));
        drain();

        // random phases under three idle profiles
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = pct_s[ph];
            recv_idle_pct = pct_r[ph];
            for (int k = 0; k < 6; k++) begin
                drain();
                random_setup();
                if (k < 3) write_reg(REG_MODE, 8'(MODE_ARP));
                for (int j = 0; j < 22; j++) begin
                    random_item(board.cfg.fx_mode);
                    if (j == 10) begin
                        // hold off until everything due has come out
                        while (board.pending.size() != 0) @(posedge i_clk);
                    end
                end
            end
        end

        drain();
        if (board.pending.size() == 0 && board.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
